### design/ucc_pkg.sv
package ucc_pkg;

  localparam int CNT_W  = 20;
  localparam int SUM_W  = 52;
  localparam int SUM2_W = 51;

  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 32;
  localparam int SQ_RAD_W   = 64;
  localparam int SQ_ROOT_W  = 32;

  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [31:0] HALF_Q30 = 32'h2000_0000;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] KIND_END  = 2'd0;
  localparam logic [1:0] KIND_BOND = 2'd1;
  localparam logic [1:0] KIND_MEAN = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         kind;
    logic [7:0]         lag;
    logic [6:0]         bond;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } ucc_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] p1_value;
    logic signed [31:0] p2_value;
    logic [CNT_W-1:0]   sample_count;
  } ucc_out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] cos_sum;
    logic [SUM2_W-1:0]       cos2_sum;
    logic [CNT_W-1:0]        count;
  } bin_t;

  typedef struct packed {
    logic end_we;
    logic bond_we;
    logic mean_we;
  } bin_we_t;

endpackage

### design/ucc_div.sv
module ucc_div import ucc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 busy,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic                 busy_r;
  logic [CW-1:0]        cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;

  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_DEN_W:0]   rem_nxt;

  // one quotient bit per cycle; quotient shifts in behind the numerator
  always_comb begin
    rem_sh  = {rem_r, num_r[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIV_NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], ge};
      rem_r <= rem_nxt[DIV_DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;

endmodule

### design/ucc_isqrt.sv
module ucc_isqrt import ucc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_RAD_W-1:0]  rad,
  output logic                 busy,
  output logic [SQ_ROOT_W-1:0] root
);

  localparam int CW    = $clog2(SQ_ROOT_W + 1);
  localparam int REM_W = SQ_ROOT_W + 2;

  logic                 busy_r;
  logic [CW-1:0]        cnt_r;
  logic [SQ_RAD_W-1:0]  rad_r;
  logic [SQ_ROOT_W-1:0] root_r;
  logic [REM_W-1:0]     rem_r;

  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic                 ge;
  logic [REM_W+1:0]     rem_nxt;

  // two radicand bits in, one root bit out per cycle
  always_comb begin
    rem_sh  = {rem_r, rad_r[SQ_RAD_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    ge      = rem_sh >= trial;
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(SQ_ROOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQ_RAD_W-3:0], 2'b00};
      root_r <= {root_r[SQ_ROOT_W-2:0], ge};
      rem_r  <= rem_nxt[REM_W-1:0];
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

### design/ucc_bins.sv
module ucc_bins import ucc_pkg::*; #(
  parameter int MAX_LAGS  = 256,
  parameter int MAX_BONDS = 128,
  parameter int LAG_W     = $clog2(MAX_LAGS),
  parameter int BA_W      = $clog2(MAX_LAGS * MAX_BONDS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LAG_W-1:0] lag_idx,
  input  logic [BA_W-1:0]  bond_idx,
  input  bin_we_t          we,
  input  bin_t             end_wd,
  input  bin_t             bond_wd,
  input  bin_t             mean_wd,
  output bin_t             end_rd,
  output bin_t             bond_rd,
  output bin_t             mean_rd,
  output logic             clearing
);

  localparam int DEPTH = MAX_LAGS * MAX_BONDS;

  bin_t end_mem  [MAX_LAGS];
  bin_t mean_mem [MAX_LAGS];
  bin_t bond_mem [DEPTH];

  logic            clearing_r;
  logic [BA_W-1:0] clr_r;
  logic            clr_lag;

  assign clr_lag = 32'(clr_r) < MAX_LAGS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == BA_W'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      bond_mem[clr_r] <= '0;
      if (clr_lag) begin
        end_mem[LAG_W'(clr_r)]  <= '0;
        mean_mem[LAG_W'(clr_r)] <= '0;
      end
    end else begin
      if (we.end_we) begin
        end_mem[lag_idx] <= end_wd;
      end
      if (we.mean_we) begin
        mean_mem[lag_idx] <= mean_wd;
      end
      if (we.bond_we) begin
        bond_mem[bond_idx] <= bond_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_rd  <= end_mem[lag_idx];
    mean_rd <= mean_mem[lag_idx];
    bond_rd <= bond_mem[bond_idx];
  end

  assign clearing = clearing_r;

endmodule

### design/unit_vector_cosine_correlator.sv
// Accumulate: the result waits on the 32-step square root and then the 64-step bit-serial
//   divider; skipped or out-of-range items go from S_NORM straight to S_OUT.
// Read: the result waits on two passes through the 64-step divider.
// One item at a time; the next item is accepted once the result sits in the output register.
// Reset: synchronous, active low; afterward a clearing pass over all MAX_LAGS*MAX_BONDS bond
//   addresses zeroes all bins while in_stall stays high.
module unit_vector_cosine_correlator import ucc_pkg::*; #(
  parameter int MAX_LAGS  = 256,
  parameter int MAX_BONDS = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ucc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ucc_out_t out_data
);

  localparam int LAG_W = $clog2(MAX_LAGS);
  localparam int BA_W  = $clog2(MAX_LAGS * MAX_BONDS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MAG     = 4'd1;
  localparam logic [3:0] S_NORM    = 4'd2;
  localparam logic [3:0] S_MAC     = 4'd3;
  localparam logic [3:0] S_NN      = 4'd4;
  localparam logic [3:0] S_SQ_GO   = 4'd5;
  localparam logic [3:0] S_SQ_WAIT = 4'd6;
  localparam logic [3:0] S_DC_WAIT = 4'd7;
  localparam logic [3:0] S_CSQ     = 4'd8;
  localparam logic [3:0] S_UPD     = 4'd9;
  localparam logic [3:0] S_RD      = 4'd10;
  localparam logic [3:0] S_D1_WAIT = 4'd11;
  localparam logic [3:0] S_D2_WAIT = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  localparam logic [1:0] G_NA  = 2'd0;
  localparam logic [1:0] G_NB  = 2'd1;
  localparam logic [1:0] G_DOT = 2'd2;

  localparam logic [3:0] MAC_LAST = 4'd9;

  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

  // mag * 2^15 / 2^len covers both the left and the right shift
  function automatic logic [14:0] scale15(input logic [31:0] m, input logic [5:0] n);
    logic [46:0] w;
    w = {m, 15'b0} >> n;
    return w[14:0];
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic bin_t add_sample(input bin_t b, input logic signed [SUM_W-1:0] cs,
                                      input logic [SUM2_W-1:0] cs2);
    bin_t r;
    r.cos_sum  = b.cos_sum + cs;
    r.cos2_sum = b.cos2_sum + cs2;
    r.count    = b.count + 1'b1;
    return r;
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  ucc_in_t     item_r;
  ucc_out_t    res_r, res_nxt;
  ucc_out_t    out_data_r;
  logic        res_load, out_load;

  logic [31:0] amag_r [3];
  logic [31:0] bmag_r [3];
  logic [2:0]  asgn_r, bsgn_r;
  logic [14:0] asc_r [3];
  logic [14:0] bsc_r [3];
  logic [3:0]  mac_cnt_r;
  logic [29:0] prod_r;
  logic [1:0]  pgrp_r;
  logic        pneg_r;
  logic [31:0] na_r, nb_r;
  logic signed [33:0] dot_r;
  logic [63:0] nn_r;
  logic [30:0] q_r;
  logic [61:0] q2_r;
  logic [SUM2_W-1:0] rsum2_r;
  logic [CNT_W-1:0]  rc_r;
  logic        rneg_r;
  logic [31:0] p1_r;

  logic        lag_ok, bond_ok, acc_ok;
  logic [LAG_W-1:0] lag_idx;
  logic [BA_W-1:0]  bond_idx;
  logic [31:0] aor, bor;
  logic [5:0]  alen, blen;
  logic        a_zero, b_zero;
  logic [14:0] op_a, op_b;
  logic [1:0]  op_grp;
  logic        op_neg;
  logic [33:0] dmag_w;
  logic        dneg;
  logic [61:0] cs2_w;
  logic signed [SUM_W-1:0] cs_w;
  logic [SUM2_W-1:0]       cs2_ext;
  bin_t        rsel;
  logic [SUM_W-1:0] rsum_mag;

  bin_we_t     we;
  bin_t        end_rd, bond_rd, mean_rd;
  bin_t        end_wd, bond_wd, mean_wd;
  logic        clearing;
  logic        end_full, bond_full, mean_full;

  logic                 div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 sq_start, sq_busy;
  logic [SQ_ROOT_W-1:0] sq_root;

  ucc_bins #(
    .MAX_LAGS  (MAX_LAGS),
    .MAX_BONDS (MAX_BONDS),
    .LAG_W     (LAG_W),
    .BA_W      (BA_W)
  ) u_bins (
    .clk      (clk),
    .rst_n    (rst_n),
    .lag_idx  (lag_idx),
    .bond_idx (bond_idx),
    .we       (we),
    .end_wd   (end_wd),
    .bond_wd  (bond_wd),
    .mean_wd  (mean_wd),
    .end_rd   (end_rd),
    .bond_rd  (bond_rd),
    .mean_rd  (mean_rd),
    .clearing (clearing)
  );

  ucc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (nn_r),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  ucc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // address decode
  always_comb begin
    lag_ok   = 32'(item_r.lag) < MAX_LAGS;
    bond_ok  = lag_ok && (32'(item_r.bond) < MAX_BONDS);
    lag_idx  = lag_ok ? LAG_W'(item_r.lag) : '0;
    bond_idx = bond_ok ? BA_W'(32'(item_r.lag) * MAX_BONDS + 32'(item_r.bond)) : '0;
    acc_ok   = (item_r.kind == KIND_END && lag_ok) || (item_r.kind == KIND_BOND && bond_ok);
  end

  always_comb begin
    aor    = amag_r[0] | amag_r[1] | amag_r[2];
    bor    = bmag_r[0] | bmag_r[1] | bmag_r[2];
    alen   = bit_len(aor);
    blen   = bit_len(bor);
    a_zero = aor == '0;
    b_zero = bor == '0;
  end

  // nine products through one multiplier: |a|^2, |b|^2, then a.b
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_grp = G_NA;
    op_neg = 1'b0;
    case (mac_cnt_r)
      4'd0: begin op_a = asc_r[0]; op_b = asc_r[0]; op_grp = G_NA; end
      4'd1: begin op_a = asc_r[1]; op_b = asc_r[1]; op_grp = G_NA; end
      4'd2: begin op_a = asc_r[2]; op_b = asc_r[2]; op_grp = G_NA; end
      4'd3: begin op_a = bsc_r[0]; op_b = bsc_r[0]; op_grp = G_NB; end
      4'd4: begin op_a = bsc_r[1]; op_b = bsc_r[1]; op_grp = G_NB; end
      4'd5: begin op_a = bsc_r[2]; op_b = bsc_r[2]; op_grp = G_NB; end
      4'd6: begin
        op_a = asc_r[0]; op_b = bsc_r[0]; op_grp = G_DOT; op_neg = asgn_r[0] ^ bsgn_r[0];
      end
      4'd7: begin
        op_a = asc_r[1]; op_b = bsc_r[1]; op_grp = G_DOT; op_neg = asgn_r[1] ^ bsgn_r[1];
      end
      4'd8: begin
        op_a = asc_r[2]; op_b = bsc_r[2]; op_grp = G_DOT; op_neg = asgn_r[2] ^ bsgn_r[2];
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    dneg    = dot_r[33];
    dmag_w  = dneg ? (~dot_r + 34'd1) : dot_r;
    cs2_w   = q2_r + 62'(HALF_Q30);
    cs2_ext = SUM2_W'(cs2_w[61:30]);
    cs_w    = SUM_W'(q_r);
    if (dneg) begin
      cs_w = -cs_w;
    end
    end_full  = end_rd.count == CNT_MAX;
    bond_full = bond_rd.count == CNT_MAX;
    mean_full = mean_rd.count == CNT_MAX;
    end_wd    = add_sample(end_rd, cs_w, cs2_ext);
    bond_wd   = add_sample(bond_rd, cs_w, cs2_ext);
    mean_wd   = add_sample(mean_rd, cs_w, cs2_ext);
  end

  always_comb begin
    rsel = '0;
    case (item_r.kind)
      KIND_END:  if (lag_ok)  rsel = end_rd;
      KIND_BOND: if (bond_ok) rsel = bond_rd;
      KIND_MEAN: if (lag_ok)  rsel = mean_rd;
      default:   rsel = '0;
    endcase
    rsum_mag = rsel.cos_sum[SUM_W-1] ? (~rsel.cos_sum + 1'b1) : rsel.cos_sum;
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    res_load  = 1'b0;
    res_nxt   = '0;
    we        = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !clearing) state_nxt = S_MAG;
      end
      S_MAG: begin
        state_nxt = (item_r.opcode == OP_READ) ? S_RD : S_NORM;
      end
      S_NORM: begin
        if (!acc_ok) begin
          res_load       = 1'b1;
          res_nxt.status = ST_FULL;
          state_nxt      = S_OUT;
        end else if (a_zero || b_zero) begin
          res_load             = 1'b1;
          res_nxt.status       = ST_ZERO;
          res_nxt.sample_count = (item_r.kind == KIND_END) ? end_rd.count : bond_rd.count;
          state_nxt            = S_OUT;
        end else begin
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (mac_cnt_r == MAC_LAST) state_nxt = S_NN;
      end
      S_NN: begin
        state_nxt = S_SQ_GO;
      end
      S_SQ_GO: begin
        sq_start  = 1'b1;
        state_nxt = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (!sq_busy) begin
          div_start = 1'b1;
          div_num   = (64'(dmag_w[31:0]) << 30) + 64'(sq_root >> 1);
          div_den   = sq_root;
          state_nxt = S_DC_WAIT;
        end
      end
      S_DC_WAIT: begin
        if (!div_busy) state_nxt = S_CSQ;
      end
      S_CSQ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        res_load = 1'b1;
        if (item_r.kind == KIND_END) begin
          we.end_we            = !end_full;
          res_nxt.status       = end_full ? ST_FULL : ST_OK;
          res_nxt.sample_count = end_full ? end_rd.count : end_wd.count;
        end else begin
          we.bond_we           = !bond_full;
          we.mean_we           = !mean_full;
          res_nxt.status       = (bond_full || mean_full) ? ST_FULL : ST_OK;
          res_nxt.sample_count = bond_full ? bond_rd.count : bond_wd.count;
        end
        state_nxt = S_OUT;
      end
      S_RD: begin
        if (rsel.count == '0) begin
          res_load       = 1'b1;
          res_nxt.status = ST_EMPTY;
          state_nxt      = S_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = 64'(rsum_mag) + 64'(rsel.count >> 1);
          div_den   = 32'(rsel.count);
          state_nxt = S_D1_WAIT;
        end
      end
      S_D1_WAIT: begin
        // P2 numerator 3*sum2 plus half of 2*count
        if (!div_busy) begin
          div_start = 1'b1;
          div_num   = (64'(rsum2_r) << 1) + 64'(rsum2_r) + 64'(rc_r);
          div_den   = 32'({rc_r, 1'b0});
          state_nxt = S_D2_WAIT;
        end
      end
      S_D2_WAIT: begin
        if (!div_busy) begin
          res_load             = 1'b1;
          res_nxt.status       = ST_OK;
          res_nxt.p1_value     = p1_r;
          res_nxt.p2_value     = div_quo[31:0] - HALF_Q30;
          res_nxt.sample_count = rc_r;
          state_nxt            = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    if (state_r == S_MAG) begin
      amag_r[0] <= abs32(item_r.ax);
      amag_r[1] <= abs32(item_r.ay);
      amag_r[2] <= abs32(item_r.az);
      bmag_r[0] <= abs32(item_r.bx);
      bmag_r[1] <= abs32(item_r.by);
      bmag_r[2] <= abs32(item_r.bz);
      asgn_r    <= {item_r.az[31], item_r.ay[31], item_r.ax[31]};
      bsgn_r    <= {item_r.bz[31], item_r.by[31], item_r.bx[31]};
    end
    if (state_r == S_NORM) begin
      for (int i = 0; i < 3; i++) begin
        asc_r[i] <= scale15(amag_r[i], alen);
        bsc_r[i] <= scale15(bmag_r[i], blen);
      end
      mac_cnt_r <= '0;
      na_r      <= '0;
      nb_r      <= '0;
      dot_r     <= '0;
    end
    if (state_r == S_MAC) begin
      mac_cnt_r <= mac_cnt_r + 1'b1;
      if (mac_cnt_r != MAC_LAST) begin
        prod_r <= 30'(op_a) * 30'(op_b);
        pgrp_r <= op_grp;
        pneg_r <= op_neg;
      end
      // accumulate the product registered on the previous cycle
      if (mac_cnt_r != '0) begin
        case (pgrp_r)
          G_NA:    na_r  <= na_r + 32'(prod_r);
          G_NB:    nb_r  <= nb_r + 32'(prod_r);
          G_DOT:   dot_r <= pneg_r ? (dot_r - 34'(prod_r)) : (dot_r + 34'(prod_r));
          default: na_r  <= na_r;
        endcase
      end
    end
    if (state_r == S_NN) begin
      nn_r <= 64'(na_r) * 64'(nb_r);
    end
    if (state_r == S_DC_WAIT && !div_busy) begin
      q_r <= (div_quo > 64'(ONE_Q30)) ? ONE_Q30[30:0] : div_quo[30:0];
    end
    if (state_r == S_CSQ) begin
      q2_r <= 62'(q_r) * 62'(q_r);
    end
    if (state_r == S_RD) begin
      rsum2_r <= rsel.cos2_sum;
      rc_r    <= rsel.count;
      rneg_r  <= rsel.cos_sum[SUM_W-1];
    end
    if (state_r == S_D1_WAIT && !div_busy) begin
      p1_r <= rneg_r ? (~div_quo[31:0] + 32'd1) : div_quo[31:0];
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || clearing;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_busy && sq_busy))
    else $error("divider and square root active together");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY) |->
      (out_data.p1_value == 32'sd0 && out_data.p2_value == 32'sd0))
    else $error("empty read carries nonzero means");

  a_p1_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.p1_value) <= 32'sd1073741824 &&
                   $signed(out_data.p1_value) >= -32'sd1073741824))
    else $error("p1 outside unit range");

endmodule

### sim/ucc_checker.sv
`timescale 1ns / 100ps

module ucc_checker import ucc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  ucc_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  ucc_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam int LAGS  = 256;
  localparam int BONDS = 128;

  longint          end_sum [LAGS];
  longint unsigned end_sum2[LAGS];
  int unsigned     end_cnt [LAGS];
  longint          bond_sum [LAGS*BONDS];
  longint unsigned bond_sum2[LAGS*BONDS];
  int unsigned     bond_cnt [LAGS*BONDS];
  longint          mean_sum [LAGS];
  longint unsigned mean_sum2[LAGS];
  int unsigned     mean_cnt [LAGS];

  ucc_out_t expected_q[$];

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint scale_comp(logic [31:0] c, int len);
    longint unsigned mag, s;
    mag = c[31] ? (64'h1_0000_0000 - {32'b0, c}) : {32'b0, c};
    s = (len > 15) ? (mag >> (len - 15)) : (mag << (15 - len));
    return c[31] ? -longint'(s) : longint'(s);
  endfunction

  // Return 0 for a zero vector; otherwise scale so the largest magnitude is in [2^14, 2^15).
  function automatic bit normalize(input logic [31:0] x, y, z, output longint sx, sy, sz);
    longint unsigned m, mx, my, mz;
    int len;
    mx = x[31] ? (64'h1_0000_0000 - {32'b0, x}) : {32'b0, x};
    my = y[31] ? (64'h1_0000_0000 - {32'b0, y}) : {32'b0, y};
    mz = z[31] ? (64'h1_0000_0000 - {32'b0, z}) : {32'b0, z};
    m = mx;
    if (my > m) m = my;
    if (mz > m) m = mz;
    sx = 0; sy = 0; sz = 0;
    if (m == 0) return 0;
    len = 0;
    while (len < 40 && (m >> len) != 0) len++;
    sx = scale_comp(x, len);
    sy = scale_comp(y, len);
    sz = scale_comp(z, len);
    return 1;
  endfunction

  function automatic ucc_out_t correlate(ucc_in_t d);
    ucc_out_t r;
    longint ax, ay, az, bx, by, bz, dot, cs, sum;
    longint unsigned na, nb, s, dm, q, cs2, sum2, sm;
    int unsigned c;
    int li, bi;
    bit full;
    r = '0;
    li = d.lag;
    bi = d.lag * BONDS + d.bond;
    if (d.opcode == OP_ACC) begin
      if (d.kind != KIND_END && d.kind != KIND_BOND) begin
        r.status = ST_FULL;
      end else if (!normalize(d.ax, d.ay, d.az, ax, ay, az) ||
                   !normalize(d.bx, d.by, d.bz, bx, by, bz)) begin
        r.status = ST_ZERO;
        r.sample_count = (d.kind == KIND_END) ? end_cnt[li] : bond_cnt[bi];
      end else begin
        na  = ax*ax + ay*ay + az*az;
        nb  = bx*bx + by*by + bz*bz;
        dot = ax*bx + ay*by + az*bz;
        s   = isqrt(na * nb);
        dm  = (dot < 0) ? -dot : dot;
        q   = round_div(dm << 30, s);
        if (q > ONE_Q30) q = ONE_Q30;
        cs  = (dot < 0) ? -longint'(q) : longint'(q);
        cs2 = (q * q + (64'd1 << 29)) >> 30;
        full = 0;
        if (d.kind == KIND_END) begin
          if (end_cnt[li] >= CNT_MAX) full = 1;
          else begin
            end_sum[li] += cs; end_sum2[li] += cs2; end_cnt[li]++;
          end
          r.sample_count = end_cnt[li];
        end else begin
          if (bond_cnt[bi] >= CNT_MAX) full = 1;
          else begin
            bond_sum[bi] += cs; bond_sum2[bi] += cs2; bond_cnt[bi]++;
          end
          if (mean_cnt[li] >= CNT_MAX) full = 1;
          else begin
            mean_sum[li] += cs; mean_sum2[li] += cs2; mean_cnt[li]++;
          end
          r.sample_count = bond_cnt[bi];
        end
        r.status = full ? ST_FULL : ST_OK;
      end
    end else begin
      sum = 0; sum2 = 0; c = 0;
      case (d.kind)
        KIND_END:  begin sum = end_sum[li];  sum2 = end_sum2[li];  c = end_cnt[li];  end
        KIND_BOND: begin sum = bond_sum[bi]; sum2 = bond_sum2[bi]; c = bond_cnt[bi]; end
        KIND_MEAN: begin sum = mean_sum[li]; sum2 = mean_sum2[li]; c = mean_cnt[li]; end
        default: c = 0;
      endcase
      if (c == 0) begin
        r.status = ST_EMPTY;
      end else begin
        sm = (sum < 0) ? -sum : sum;
        q  = round_div(sm, c);
        r.p1_value = (sum < 0) ? -longint'(q) : longint'(q);
        r.p2_value = longint'(round_div(3 * sum2, 2 * longint'(c))) - longint'(HALF_Q30);
        r.sample_count = c;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    ucc_out_t e;
    if (!rst_n) begin
      fail_count <= 0;
      foreach (end_cnt[i]) begin
        end_sum[i] = 0; end_sum2[i] = 0; end_cnt[i] = 0;
        mean_sum[i] = 0; mean_sum2[i] = 0; mean_cnt[i] = 0;
      end
      foreach (bond_cnt[i]) begin
        bond_sum[i] = 0; bond_sum2[i] = 0; bond_cnt[i] = 0;
      end
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(correlate(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.status !== out_data.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          if (e.p1_value !== out_data.p1_value)
            $display("%0t: p1_value expected %0d actual %0d", $time, e.p1_value,
                     out_data.p1_value);
          if (e.p2_value !== out_data.p2_value)
            $display("%0t: p2_value expected %0d actual %0d", $time, e.p2_value,
                     out_data.p2_value);
          if (e.sample_count !== out_data.sample_count)
            $display("%0t: sample_count expected %0d actual %0d", $time, e.sample_count,
                     out_data.sample_count);
          if (e !== out_data) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

### sim/unit_vector_cosine_correlator_tb.sv
`timescale 1ns / 100ps

module unit_vector_cosine_correlator_tb import ucc_pkg::*;;

  localparam int          RANDOM_ITEMS = 800;
  localparam int          IDLE_LIMIT   = 150000;
  localparam logic [1:0]  KIND_SPARE   = 2'd3;
  localparam logic [31:0] MAX_POS      = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_NEG      = 32'h8000_0000;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  ucc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 0;
  ucc_out_t out_data;
  int       fail_count;
  int       pending;
  int       beats_out = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;

  always #5 clk = ~clk;

  unit_vector_cosine_correlator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ucc_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (out_valid && !out_stall) beats_out <= beats_out + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("unit_vector_cosine_correlator regression: fail");
      $finish;
    end
  end

  // Receiver: one long hold-off early on, then shifting stall patterns.
  initial begin
    int mode;
    bit held;
    held = 0;
    mode = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (!held && beats_out >= 25) begin
        held = 1;
        out_stall <= 1;
        repeat (1500) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  task automatic send(ucc_in_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= d;
    in_valid <= 1;
    @(posedge clk iff (in_valid && !in_stall));
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ($urandom_range(0, 1) == 0) ? MAX_POS : MAX_NEG;
      2, 3:    return $urandom_range(0, 600) - 300;
      default: return $urandom();
    endcase
  endfunction

  function automatic ucc_in_t vec_item(logic op, logic [1:0] kind, logic [7:0] lag,
                                       logic [6:0] bond,
                                       logic [31:0] ax, ay, az, bx, by, bz);
    ucc_in_t d;
    d.opcode = op; d.kind = kind; d.lag = lag; d.bond = bond;
    d.ax = ax; d.ay = ay; d.az = az; d.bx = bx; d.by = by; d.bz = bz;
    return d;
  endfunction

  function automatic ucc_in_t rand_item();
    ucc_in_t d;
    d = '0;
    d.opcode = ($urandom_range(0, 9) < 7) ? OP_ACC : OP_READ;
    d.kind   = ($urandom_range(0, 19) == 0) ? KIND_SPARE : $urandom_range(0, 2);
    if (d.opcode == OP_ACC && d.kind == KIND_MEAN && $urandom_range(0, 3) != 0)
      d.kind = KIND_BOND;
    // Keep most beats on a few bins so reads find samples.
    d.lag  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    d.bond = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 127);
    d.ax = rand_comp(); d.ay = rand_comp(); d.az = rand_comp();
    d.bx = rand_comp(); d.by = rand_comp(); d.bz = rand_comp();
    return d;
  endfunction

  initial begin
    ucc_in_t directed[$];
    repeat (10) @(posedge clk);
    rst_n <= 1;
    directed = '{
      vec_item(OP_READ, KIND_END,  8'd0, 7'd0, 0, 0, 0, 0, 0, 0),
      vec_item(OP_ACC, KIND_END, 8'd0, 7'd0, 0, 0, 0, 32'h10000, 0, 0),
      vec_item(OP_ACC, KIND_END, 8'd0, 7'd0, 32'h10000, 0, 0, 0, 0, 0),
      vec_item(OP_ACC, KIND_END, 8'd0, 7'd0, 32'h10000, 0, 0, 32'h30000, 0, 0),
      vec_item(OP_ACC, KIND_END, 8'd0, 7'd0, 32'h10000, 0, 0, -32'sh20000, 0, 0),
      vec_item(OP_ACC, KIND_END, 8'd0, 7'd0, 32'h10000, 0, 0, 0, 32'h10000, 0),
      vec_item(OP_ACC, KIND_END, 8'd255, 7'd0, MAX_POS, MAX_NEG, MAX_POS,
               MAX_NEG, MAX_NEG, MAX_POS),
      vec_item(OP_ACC, KIND_END, 8'd255, 7'd0, 1, 1, 1, 32'hFFFF_FFFF, 1, 1),
      vec_item(OP_ACC, KIND_BOND, 8'd255, 7'd127, MAX_NEG, 0, 0, MAX_NEG, 0, 0),
      vec_item(OP_ACC, KIND_BOND, 8'd255, 7'd127, 3, 4, 5, -4, 3, 0),
      vec_item(OP_ACC, KIND_BOND, 8'd255, 7'd0, 32'h12345, 32'h6789, 7, 9, 32'hABCDE, 1),
      vec_item(OP_ACC, KIND_BOND, 8'd1, 7'd5, 0, 0, 0, 0, 0, 0),
      vec_item(OP_ACC, KIND_MEAN, 8'd0, 7'd0, 1, 0, 0, 1, 0, 0),
      vec_item(OP_ACC, KIND_SPARE, 8'd0, 7'd0, 1, 0, 0, 1, 0, 0),
      vec_item(OP_READ, KIND_END,  8'd0, 7'd0, 0, 0, 0, 0, 0, 0),
      vec_item(OP_READ, KIND_END,  8'd255, 7'd0, 0, 0, 0, 0, 0, 0),
      vec_item(OP_READ, KIND_BOND, 8'd255, 7'd127, 0, 0, 0, 0, 0, 0),
      vec_item(OP_READ, KIND_BOND, 8'd255, 7'd0, 0, 0, 0, 0, 0, 0),
      vec_item(OP_READ, KIND_MEAN, 8'd255, 7'd0, 0, 0, 0, 0, 0, 0),
      vec_item(OP_READ, KIND_MEAN, 8'd7, 7'd0, 0, 0, 0, 0, 0, 0),
      vec_item(OP_READ, KIND_SPARE, 8'd255, 7'd127, 0, 0, 0, 0, 0, 0)
    };
    foreach (directed[i]) send(directed[i]);
    repeat (RANDOM_ITEMS) send(rand_item());
    in_valid <= 0;
    // let the checker record the last accepted beat before draining
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("unit_vector_cosine_correlator regression: pass");
    else $display("unit_vector_cosine_correlator regression: fail");
    $finish;
  end

endmodule
